@@ hw/rtl/tts_pkg.sv @@
package tts_pkg;

    // Field widths of the command and result items.
    localparam int unsigned OP_W     = 2;
    localparam int unsigned SLOT_W   = 6;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned TICKS_W  = 16;
    localparam int unsigned COUNT_W  = 16;

    // Command codes.
    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2,
        OP_DISP = 2'd3
    } t_op;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RD   = 2'd1,
        S_EX   = 2'd2,
        S_FIN  = 2'd3
    } t_state;

    // One command item.
    typedef struct packed {
        t_op                 op;
        logic [SLOT_W-1:0]   slot_index;
        logic [HANDLE_W-1:0] task_handle;
        logic [TICKS_W-1:0]  first_delay;
        logic [TICKS_W-1:0]  repeat_period;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic                status;
        logic [SLOT_W-1:0]   slot_out;
        logic [HANDLE_W-1:0] handle_out;
        logic                task_ran;
        logic                last;
    } t_res;

    // One entry of the slot table.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TICKS_W-1:0]  delay;
        logic [TICKS_W-1:0]  period;
        logic [COUNT_W-1:0]  pending;
    } t_slot;

    // Flags from the slot update unit to the sequencer.
    typedef struct packed {
        logic we;   // entry changes and must be written back
        logic hit;  // slot matches: free slot on add, runnable slot on dispatch
    } t_alu_flags;

endpackage

@@ hw/rtl/tts_stream_if.sv @@
interface tts_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

@@ hw/rtl/tick_task_scheduler.sv @@
// Task slot table for a cooperative time-triggered scheduler.
// Commands arrive on i_cmd (valid/ready, one item per command) and results
// leave on o_res (valid/ready). Add, delete and tick give one result each;
// dispatch gives one result per released task in ascending slot order, or
// a single empty result when nothing is pending. The last result of each
// command carries last = 1.
// Delete clears its entry when accepted; its result passes through the
// final-result register to the output register. Add, tick and dispatch
// walk the table through one shared slot update unit, each slot as a memory
// read, then an update and write back; an add stops at the first free slot.
// The command side is ready only between commands, so the sustained rate
// is one command per walk plus the time the receiver takes the results.
// A result sits in an output register and a second one in a holding
// register; while the receiver stalls, a dispatch walk keeps going until a
// third result is found, then waits. The final result waits the same way.
// Synchronous reset empties the table at once (per-entry written flags)
// and drops any result in flight; the block is ready the cycle after.
module tick_task_scheduler #(
    parameter int unsigned SLOTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tts_stream_if.sink                    i_cmd,
    tts_stream_if.source                  o_res
);

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    tts_pkg::t_state     r_state, n_state;
    tts_pkg::t_cmd       r_cmd, n_cmd;
    logic [AW-1:0]       r_idx, n_idx;
    tts_pkg::t_res       r_fin, n_fin;
    tts_pkg::t_res       r_held, n_held;
    logic                r_held_vld, n_held_vld;
    tts_pkg::t_res       r_out, n_out;
    logic                r_ovalid, n_ovalid;

    tts_pkg::t_slot      w_entry;
    tts_pkg::t_slot      w_new_entry;
    tts_pkg::t_alu_flags w_flags;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    tts_pkg::t_slot      w_wdata;
    logic                w_accept;
    logic                w_del_ok;
    logic                w_last_slot;
    logic                w_out_free;
    logic                w_stall;
    tts_pkg::t_res       w_disp_res;

    assign i_cmd.ready = (r_state == tts_pkg::S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_del_ok    = ({1'b0, i_cmd.data.slot_index} < (tts_pkg::SLOT_W + 1)'(SLOTS));
    assign w_last_slot = (r_idx == AW'(SLOTS - 1));
    assign w_out_free  = !r_ovalid || o_res.ready;

    // A runnable slot found while the holding and output registers are both full must hold.
    assign w_stall = (r_state == tts_pkg::S_EX) && (r_cmd.op == tts_pkg::OP_DISP)
                     && w_flags.hit && r_held_vld && !w_out_free;

    // Result for the slot released by dispatch.
    always_comb begin
        w_disp_res            = '0;
        w_disp_res.slot_out   = tts_pkg::SLOT_W'(r_idx);
        w_disp_res.handle_out = w_entry.handle;
        w_disp_res.task_ran   = 1'b1;
    end

    tts_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_entry)
    );

    tts_slot_alu u_alu (
        .i_cmd   (r_cmd),
        .i_entry (w_entry),
        .o_entry (w_new_entry),
        .o_flags (w_flags)
    );

    // Table write port: delete clears at once, walks write back updates.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_new_entry;
        if (w_accept && (i_cmd.data.op == tts_pkg::OP_DEL) && w_del_ok) begin
            w_we    = 1'b1;
            w_waddr = i_cmd.data.slot_index[AW-1:0];
            w_wdata = '0;
        end else if ((r_state == tts_pkg::S_EX) && w_flags.we && !w_stall) begin
            w_we = 1'b1;
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tts_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_cmd.data.op == tts_pkg::OP_DEL) ? tts_pkg::S_FIN
                                                                 : tts_pkg::S_RD;
                end
            end
            tts_pkg::S_RD: begin
                n_state = tts_pkg::S_EX;
            end
            tts_pkg::S_EX: begin
                if (!w_stall) begin
                    if (w_last_slot || ((r_cmd.op == tts_pkg::OP_ADD) && w_flags.hit)) begin
                        n_state = tts_pkg::S_FIN;
                    end else begin
                        n_state = tts_pkg::S_RD;
                    end
                end
            end
            tts_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = tts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tts_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath registers of the sequencer.
    always_comb begin
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_fin      = r_fin;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_out      = r_out;
        n_ovalid   = r_ovalid && !o_res.ready;
        case (r_state)
            tts_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd        = i_cmd.data;
                    n_idx        = '0;
                    n_held_vld   = 1'b0;
                    n_fin        = '0;
                    n_fin.status = !w_del_ok;
                    n_fin.last   = 1'b1;
                end
            end
            tts_pkg::S_EX: begin
                if (!w_stall) begin
                    n_fin      = '0;
                    n_fin.last = 1'b1;
                    case (r_cmd.op)
                        tts_pkg::OP_ADD: begin
                            if (w_flags.hit) begin
                                n_fin.slot_out = tts_pkg::SLOT_W'(r_idx);
                            end else begin
                                n_fin.status = 1'b1;
                            end
                        end
                        tts_pkg::OP_DISP: begin
                            if (w_flags.hit) begin
                                if (r_held_vld) begin
                                    n_out    = r_held;
                                    n_ovalid = 1'b1;
                                end
                                n_held     = w_disp_res;
                                n_held_vld = !w_last_slot;
                                n_fin      = w_disp_res;
                                n_fin.last = 1'b1;
                            end else if (w_last_slot) begin
                                n_held_vld = 1'b0;
                                if (r_held_vld) begin
                                    n_fin      = r_held;
                                    n_fin.last = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_fin      = '0;
                            n_fin.last = 1'b1;
                        end
                    endcase
                    if (!w_last_slot) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            tts_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_out    = r_fin;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tts_pkg::S_IDLE;
            r_idx      <= '0;
            r_held_vld <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_held_vld <= n_held_vld;
            r_ovalid   <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_fin  <= n_fin;
        r_held <= n_held;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    // A held dispatch result only exists during a dispatch walk.
    a_held_in_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_vld |-> ((r_cmd.op == tts_pkg::OP_DISP) && (r_state != tts_pkg::S_IDLE)))
        else $error("held result outside a dispatch walk");

    // A released task always names a used slot and never carries an error.
    a_ran_only_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.task_ran) |-> (!r_out.status && (r_out.handle_out != '0)))
        else $error("released task with an error or an empty handle");

    // A result without last is always followed within the same dispatch walk.
    a_not_last_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_out.last) |-> (r_state != tts_pkg::S_IDLE))
        else $error("intermediate result after the walk ended");

    // The final result of a command is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_res.ready && (r_state == tts_pkg::S_FIN)) |=>
        (r_state == tts_pkg::S_FIN))
        else $error("final result loaded over a stalled result");
`endif

endmodule

@@ hw/rtl/tts_slot_mem.sv @@
module tts_slot_mem #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  tts_pkg::t_slot        i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output tts_pkg::t_slot        o_rdata
);

    tts_pkg::t_slot r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    tts_pkg::t_slot r_rdata;
    logic r_rd_vld;

    // Table storage with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Per-entry written flags; an unwritten entry reads as an empty slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

@@ hw/rtl/tts_slot_alu.sv @@
module tts_slot_alu (
    input  tts_pkg::t_cmd       i_cmd,
    input  tts_pkg::t_slot      i_entry,
    output tts_pkg::t_slot      o_entry,
    output tts_pkg::t_alu_flags o_flags
);

    logic w_used;
    logic w_due;
    logic w_sat;

    assign w_used = (i_entry.handle != '0);
    assign w_due  = (i_entry.delay == '0);
    assign w_sat  = (i_entry.pending == '1);

    // Update of one slot for the command being walked.
    always_comb begin
        o_entry = i_entry;
        o_flags = '0;
        case (i_cmd.op)
            tts_pkg::OP_ADD: begin
                o_flags.hit     = !w_used;
                o_flags.we      = !w_used;
                o_entry.handle  = i_cmd.task_handle;
                o_entry.delay   = i_cmd.first_delay;
                o_entry.period  = i_cmd.repeat_period;
                o_entry.pending = '0;
            end
            tts_pkg::OP_TICK: begin
                o_flags.we = w_used;
                if (w_due) begin
                    if (i_entry.period != '0) begin
                        o_entry.delay = i_entry.period - 1'b1;
                    end
                    if (!w_sat) begin
                        o_entry.pending = i_entry.pending + 1'b1;
                    end
                end else begin
                    o_entry.delay = i_entry.delay - 1'b1;
                end
            end
            tts_pkg::OP_DISP: begin
                o_flags.hit     = w_used && (i_entry.pending != '0);
                o_flags.we      = o_flags.hit;
                o_entry.pending = i_entry.pending - 1'b1;
                if (i_entry.period == '0) begin
                    o_entry.handle = '0;
                end
            end
            default: begin
                o_entry = i_entry;
                o_flags = '0;
            end
        endcase
    end

endmodule

@@ tb/sv/tick_task_scheduler_tb.sv @@
`timescale 1ns / 100ps

module tick_task_scheduler_tb;

    localparam int unsigned SLOTS = 8;
    localparam int unsigned RAND_PER_PHASE = 72;

    // One queued command item together with the traffic shape it is sent with.
    typedef struct {
        tts_pkg::t_cmd cmd;
        int            idle_pct;
        int            stall_pct;
        bit            drain;
        int            hold;
    } t_stim;

    logic i_clk;
    logic i_rst_n;

    tts_stream_if #(.t_payload(tts_pkg::t_cmd)) cmd_if ();
    tts_stream_if #(.t_payload(tts_pkg::t_res)) res_if ();

    tick_task_scheduler #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    // Shadow copy of the slot table.
    logic [tts_pkg::HANDLE_W-1:0] tbl_handle  [SLOTS];
    logic [tts_pkg::TICKS_W-1:0]  tbl_delay   [SLOTS];
    logic [tts_pkg::TICKS_W-1:0]  tbl_period  [SLOTS];
    logic [tts_pkg::COUNT_W-1:0]  tbl_pending [SLOTS];

    t_stim         cmd_backlog [$];
    tts_pkg::t_res due_results [$];
    t_stim         cur_item;
    tts_pkg::t_res want;
    int            mismatches;
    int            rx_stall_pct;
    int            hold_req;
    int            hold_left;
    int            next_hold;
    int            ri;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Update the shadow table for one accepted command and queue its results.
    task automatic apply_command(input tts_pkg::t_cmd c);
        int            s;
        int            found;
        tts_pkg::t_res r;
        tts_pkg::t_res burst [$];
        r = '0;
        r.last = 1'b1;
        case (c.op)
            tts_pkg::OP_ADD: begin
                found = -1;
                for (s = 0; s < SLOTS; s++) begin
                    if (tbl_handle[s] == '0) begin
                        found = s;
                        break;
                    end
                end
                if (found >= 0) begin
                    tbl_handle[found]  = c.task_handle;
                    tbl_delay[found]   = c.first_delay;
                    tbl_period[found]  = c.repeat_period;
                    tbl_pending[found] = '0;
                    r.slot_out = found[tts_pkg::SLOT_W-1:0];
                end else begin
                    r.status = 1'b1;
                end
                due_results.push_back(r);
            end
            tts_pkg::OP_DEL: begin
                if (c.slot_index < SLOTS) begin
                    tbl_handle[c.slot_index]  = '0;
                    tbl_delay[c.slot_index]   = '0;
                    tbl_period[c.slot_index]  = '0;
                    tbl_pending[c.slot_index] = '0;
                end else begin
                    r.status = 1'b1;
                end
                due_results.push_back(r);
            end
            tts_pkg::OP_TICK: begin
                for (s = 0; s < SLOTS; s++) begin
                    if (tbl_handle[s] != '0) begin
                        if (tbl_delay[s] == '0) begin
                            if (tbl_period[s] != '0) begin
                                tbl_delay[s] = tbl_period[s] - 1'b1;
                            end
                            // The run count sticks at its maximum.
                            if (tbl_pending[s] != '1) begin
                                tbl_pending[s] = tbl_pending[s] + 1'b1;
                            end
                        end else begin
                            tbl_delay[s] = tbl_delay[s] - 1'b1;
                        end
                    end
                end
                due_results.push_back(r);
            end
            default: begin
                // Dispatch: release each runnable slot once, lowest slot first.
                for (s = 0; s < SLOTS; s++) begin
                    if (tbl_handle[s] != '0 && tbl_pending[s] != '0) begin
                        tbl_pending[s] = tbl_pending[s] - 1'b1;
                        r = '0;
                        r.slot_out = s[tts_pkg::SLOT_W-1:0];
                        r.handle_out = tbl_handle[s];
                        r.task_ran = 1'b1;
                        burst.push_back(r);
                        if (tbl_period[s] == '0) begin
                            tbl_handle[s] = '0;
                        end
                    end
                end
                if (burst.size() == 0) begin
                    r = '0;
                    r.last = 1'b1;
                    due_results.push_back(r);
                end else begin
                    r = burst.pop_back();
                    r.last = 1'b1;
                    burst.push_back(r);
                    foreach (burst[k]) begin
                        due_results.push_back(burst[k]);
                    end
                end
            end
        endcase
    endtask

    function automatic tts_pkg::t_cmd make_cmd(input tts_pkg::t_op op, input int idx,
                                               input int h, input int d, input int p);
        tts_pkg::t_cmd c;
        c.op            = op;
        c.slot_index    = idx[tts_pkg::SLOT_W-1:0];
        c.task_handle   = h[tts_pkg::HANDLE_W-1:0];
        c.first_delay   = d[tts_pkg::TICKS_W-1:0];
        c.repeat_period = p[tts_pkg::TICKS_W-1:0];
        return c;
    endfunction

    // Random command with small delays and periods most of the time, so tasks fire often.
    function automatic tts_pkg::t_cmd random_cmd();
        tts_pkg::t_cmd c;
        int            pick;
        pick            = $urandom_range(99, 0);
        c.slot_index    = tts_pkg::SLOT_W'($urandom_range(63, 0));
        c.task_handle   = tts_pkg::HANDLE_W'($urandom);
        c.first_delay   = tts_pkg::TICKS_W'($urandom);
        c.repeat_period = tts_pkg::TICKS_W'($urandom);
        if (pick < 25) begin
            c.op = tts_pkg::OP_ADD;
            if ($urandom_range(15, 0) == 0) begin
                c.task_handle = '0;
            end
            if ($urandom_range(7, 0) != 0) begin
                c.first_delay = tts_pkg::TICKS_W'($urandom_range(4, 0));
            end
            if ($urandom_range(7, 0) != 0) begin
                c.repeat_period = tts_pkg::TICKS_W'($urandom_range(3, 0));
            end
        end else if (pick < 40) begin
            c.op = tts_pkg::OP_DEL;
            if ($urandom_range(4, 0) != 0) begin
                c.slot_index = tts_pkg::SLOT_W'($urandom_range(SLOTS - 1, 0));
            end
        end else if (pick < 72) begin
            c.op = tts_pkg::OP_TICK;
        end else begin
            c.op = tts_pkg::OP_DISP;
        end
        return c;
    endfunction

    task automatic queue_cmd(input tts_pkg::t_cmd c, input int idle, input int stall,
                             input bit drain, input int hold);
        t_stim st;
        st.cmd       = c;
        st.idle_pct  = idle;
        st.stall_pct = stall;
        st.drain     = drain;
        st.hold      = hold;
        cmd_backlog.push_back(st);
    endtask

    // Command driver: predicts on acceptance, then offers the next item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            hold_req     <= 0;
            rx_stall_pct <= 0;
            for (ri = 0; ri < SLOTS; ri++) begin
                tbl_handle[ri]  = '0;
                tbl_delay[ri]   = '0;
                tbl_period[ri]  = '0;
                tbl_pending[ri] = '0;
            end
        end else begin
            next_hold = 0;
            if (cmd_if.valid && cmd_if.ready) begin
                apply_command(cmd_if.data);
            end
            if (!(cmd_if.valid && !cmd_if.ready)) begin
                if (cmd_backlog.size() != 0
                        && (!cmd_backlog[0].drain || due_results.size() == 0)
                        && $urandom_range(99, 0) >= cmd_backlog[0].idle_pct) begin
                    cur_item = cmd_backlog.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.data  <= cur_item.cmd;
                    rx_stall_pct <= cur_item.stall_pct;
                    next_hold = cur_item.hold;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
            hold_req <= next_hold;
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_req > 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_req;
        end else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            res_if.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // Result monitor: each accepted item is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result item: %p", res_if.data);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (res_if.data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.data.status);
                    mismatches++;
                end
                if (res_if.data.slot_out !== want.slot_out) begin
                    $error("slot_out: expected %0d, got %0d",
                           want.slot_out, res_if.data.slot_out);
                    mismatches++;
                end
                if (res_if.data.handle_out !== want.handle_out) begin
                    $error("handle_out: expected %0h, got %0h",
                           want.handle_out, res_if.data.handle_out);
                    mismatches++;
                end
                if (res_if.data.task_ran !== want.task_ran) begin
                    $error("task_ran: expected %0d, got %0d",
                           want.task_ran, res_if.data.task_ran);
                    mismatches++;
                end
                if (res_if.data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, res_if.data.last);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int ph;
        int k;
        int idle;
        int stall;
        mismatches   = 0;
        i_rst_n      = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        res_if.ready = 1'b0;
        hold_req     = 0;
        hold_left    = 0;
        rx_stall_pct = 0;

        // Directed: one-shot, zero handle, extreme fields, full table.
        queue_cmd(make_cmd(tts_pkg::OP_ADD, 0, 16'hFFFF, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_ADD, 63, 0, 16'hFFFF, 16'hFFFF), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_ADD, 0, 1, 0, 1), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_ADD, 0, 16'hA5A5, 16'hFFFF, 16'hFFFF), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_ADD, 0, 16'h5A5A, 1, 2), 0, 0, 0, 0);
        for (k = 0; k < 4; k++) begin
            queue_cmd(make_cmd(tts_pkg::OP_ADD, 0, 16'h0100 + k, 2, k % 2 * 3), 0, 0, 0, 0);
        end
        queue_cmd(make_cmd(tts_pkg::OP_ADD, 0, 16'h7777, 0, 0), 0, 0, 0, 0);
        // Nothing pending yet, then deletes out of range and in range.
        queue_cmd(make_cmd(tts_pkg::OP_DISP, 0, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_DEL, 63, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_DEL, SLOTS, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_DEL, SLOTS - 1, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_TICK, 0, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_DISP, 0, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_TICK, 0, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_TICK, 0, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_DISP, 0, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_DISP, 0, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_DEL, 0, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_DEL, 5, 0, 0, 0), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_TICK, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, 0, 0, 0);
        queue_cmd(make_cmd(tts_pkg::OP_DISP, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, 0, 0, 0);

        // Random phases: free flow with a long receiver hold-off, sender gaps,
        // receiver stalls after a full drain, then light gaps on both sides.
        for (ph = 0; ph < 4; ph++) begin
            idle  = (ph == 1) ? 55 : (ph == 3) ? 9 : 0;
            stall = (ph == 2) ? 55 : (ph == 3) ? 9 : 0;
            for (k = 0; k < RAND_PER_PHASE; k++) begin
                queue_cmd(random_cmd(), idle, stall, (ph == 2 && k == 0),
                          (ph == 0 && k == 10) ? 300 : 0);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_if.valid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4 * SLOTS + 20) @(posedge i_clk);

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #400_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
